@@ src/qnr_pkg.sv @@
package qnr_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // square root operand: delta scaled up by the fraction bits, padded to even width
  localparam int SQ_IN_W  = WORD_BITS + FRAC_BITS + ((WORD_BITS + FRAC_BITS) % 2);
  localparam int SQ_W     = SQ_IN_W / 2;
  localparam int SQ_REM_W = SQ_W + 2;

  localparam int NUM_W   = WORD_BITS + 2;          // signed numerator
  localparam int NM_W    = WORD_BITS + 1;          // numerator magnitude
  localparam int DEN_W   = WORD_BITS + 1;          // 2 * |a|
  localparam int DIV_N_W = NM_W + FRAC_BITS;       // scaled dividend and quotient

  localparam int IN_DATA_W  = 3 * WORD_BITS + ((8 - (3 * WORD_BITS) % 8) % 8);
  localparam int OUT_BITS   = WORD_BITS + 2;
  localparam int OUT_DATA_W = OUT_BITS + ((8 - OUT_BITS % 8) % 8);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NEG_DISC = 2'd1;
  localparam logic [1:0] ST_ZERO_A   = 2'd2;
  localparam logic [1:0] ST_SAT      = 2'd3;

  typedef struct packed {
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    logic [1:0]           status;
  } sq_meta_t;

  typedef struct packed {
    logic       neg;
    logic [1:0] status;
  } div_meta_t;

endpackage

@@ src/qnr_sqrt.sv @@
module qnr_sqrt
  import qnr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [SQ_IN_W-1:0] in_x,
  input  sq_meta_t           in_meta,
  output logic               out_valid,
  output logic [SQ_W-1:0]    out_root,
  output sq_meta_t           out_meta
);

  logic                v    [0:SQ_W];
  logic [SQ_IN_W-1:0]  x    [0:SQ_W];
  logic [SQ_REM_W-1:0] rem  [0:SQ_W];
  logic [SQ_W-1:0]     root [0:SQ_W];
  sq_meta_t            meta [0:SQ_W];

  assign v[0]    = in_valid;
  assign x[0]    = in_x;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign meta[0] = in_meta;

  // one result bit per stage, two radicand bits consumed
  for (genvar k = 0; k < SQ_W; k++) begin : g_stage
    logic [SQ_REM_W+1:0] cat;
    logic [SQ_REM_W+1:0] trial;
    logic [SQ_REM_W+1:0] diff;
    logic                ge;

    assign cat   = {rem[k], x[k][SQ_IN_W-1 -: 2]};
    assign trial = {{(SQ_REM_W - SQ_W){1'b0}}, root[k], 2'b01};
    assign ge    = cat >= trial;
    assign diff  = cat - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x[k+1]    <= x[k] << 2;
        meta[k+1] <= meta[k];
        if (ge) begin
          rem[k+1]  <= diff[SQ_REM_W-1:0];
          root[k+1] <= {root[k][SQ_W-2:0], 1'b1};
        end else begin
          rem[k+1]  <= cat[SQ_REM_W-1:0];
          root[k+1] <= {root[k][SQ_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[SQ_W];
  assign out_root  = root[SQ_W];
  assign out_meta  = meta[SQ_W];

endmodule

@@ src/qnr_div.sv @@
module qnr_div
  import qnr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [DIV_N_W-1:0] in_num,
  input  logic [DEN_W-1:0]   in_den,
  input  div_meta_t          in_meta,
  output logic               out_valid,
  output logic [DIV_N_W-1:0] out_quo,
  output logic               out_inexact,
  output div_meta_t          out_meta
);

  logic               v    [0:DIV_N_W];
  logic [DIV_N_W-1:0] num  [0:DIV_N_W];
  logic [DEN_W-1:0]   den  [0:DIV_N_W];
  logic [DEN_W-1:0]   r    [0:DIV_N_W];
  logic [DIV_N_W-1:0] q    [0:DIV_N_W];
  div_meta_t          meta [0:DIV_N_W];

  assign v[0]    = in_valid;
  assign num[0]  = in_num;
  assign den[0]  = in_den;
  assign r[0]    = '0;
  assign q[0]    = '0;
  assign meta[0] = in_meta;

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DIV_N_W; k++) begin : g_stage
    logic [DEN_W:0] cat;
    logic [DEN_W:0] diff;
    logic           ge;

    assign cat  = {r[k], num[k][DIV_N_W-1]};
    assign ge   = cat >= {1'b0, den[k]};
    assign diff = cat - {1'b0, den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num[k+1]  <= num[k] << 1;
        den[k+1]  <= den[k];
        meta[k+1] <= meta[k];
        r[k+1]    <= ge ? diff[DEN_W-1:0] : cat[DEN_W-1:0];
        q[k+1]    <= {q[k][DIV_N_W-2:0], ge};
      end
    end
  end

  assign out_valid   = v[DIV_N_W];
  assign out_quo     = q[DIV_N_W];
  assign out_inexact = |r[DIV_N_W];
  assign out_meta    = meta[DIV_N_W];

endmodule

@@ src/quadratic_nearest_root_top.sv @@
// pipeline from input beat to output beat: 24 root stages, 1 numerator stage, 49 quotient
// stages and 1 output register with the saturation logic in front of it
// throughput: one beat per cycle; the whole pipeline holds while the output beat waits
// reset: synchronous rst clears every stage valid bit, data registers are not reset
module quadratic_nearest_root_top
  import qnr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // coef_a, coef_b, discriminant
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // root, status, zero pad
);

  logic                 en;
  logic [WORD_BITS-1:0] in_a, in_b, in_disc;
  sq_meta_t             sq_in_meta;
  logic [SQ_IN_W-1:0]   sq_x;

  logic                 sq_valid;
  logic [SQ_W-1:0]      sq_root;
  sq_meta_t             sq_meta;

  logic                 nu_valid;
  logic [DIV_N_W-1:0]   nu_num;
  logic [DEN_W-1:0]     nu_den;
  div_meta_t            nu_meta;

  logic signed [NUM_W-1:0] n_b, n_s, n_val;
  logic [NUM_W-1:0]        n_mag;
  logic                    a_neg;
  logic [WORD_BITS-1:0]    a_mag;

  logic                 dv_valid;
  logic [DIV_N_W-1:0]   dv_quo;
  logic                 dv_inexact;
  div_meta_t            dv_meta;
  logic [DIV_N_W:0]     mag;
  logic                 sat_pos, sat_neg;

  logic [WORD_BITS-1:0] root;
  logic [1:0]           status;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign in_a    = s_tdata[WORD_BITS-1:0];
  assign in_b    = s_tdata[2*WORD_BITS-1:WORD_BITS];
  assign in_disc = s_tdata[3*WORD_BITS-1:2*WORD_BITS];

  assign sq_x = SQ_IN_W'({in_disc, {FRAC_BITS{1'b0}}});

  always_comb begin
    sq_in_meta.a = in_a;
    sq_in_meta.b = in_b;
    if (in_disc[WORD_BITS-1]) begin
      sq_in_meta.status = ST_NEG_DISC;
    end else if (in_a == '0) begin
      sq_in_meta.status = ST_ZERO_A;
    end else begin
      sq_in_meta.status = ST_OK;
    end
  end

  qnr_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_x      (sq_x),
    .in_meta   (sq_in_meta),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_meta  (sq_meta)
  );

  // numerator picks the smaller root by the sign of a
  always_comb begin
    a_neg = sq_meta.a[WORD_BITS-1];
    a_mag = a_neg ? (WORD_BITS)'(-sq_meta.a) : sq_meta.a;
    n_b   = NUM_W'($signed(sq_meta.b));
    n_s   = $signed({{(NUM_W - SQ_W){1'b0}}, sq_root});
    n_val = a_neg ? (-n_b + n_s) : (-n_b - n_s);
    n_mag = n_val[NUM_W-1] ? NUM_W'(-n_val) : NUM_W'(n_val);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nu_valid <= 1'b0;
    end else if (en) begin
      nu_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nu_num         <= {n_mag[NM_W-1:0], {FRAC_BITS{1'b0}}};
      nu_den         <= {a_mag, 1'b0};
      nu_meta.neg    <= (n_val != '0) && (n_val[NUM_W-1] != a_neg);
      nu_meta.status <= sq_meta.status;
    end
  end

  qnr_div u_div (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (nu_valid),
    .in_num      (nu_num),
    .in_den      (nu_den),
    .in_meta     (nu_meta),
    .out_valid   (dv_valid),
    .out_quo     (dv_quo),
    .out_inexact (dv_inexact),
    .out_meta    (dv_meta)
  );

  // floor toward minus infinity: negative results round their magnitude up
  always_comb begin
    mag     = {1'b0, dv_quo} + {{DIV_N_W{1'b0}}, dv_inexact};
    sat_pos = |dv_quo[DIV_N_W-1:WORD_BITS-1];
    sat_neg = (|mag[DIV_N_W:WORD_BITS]) || (mag[WORD_BITS-1] && (|mag[WORD_BITS-2:0]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_meta.status != ST_OK) begin
        root   <= '0;
        status <= dv_meta.status;
      end else if (dv_meta.neg) begin
        root   <= sat_neg ? {1'b1, {(WORD_BITS-1){1'b0}}} : WORD_BITS'(-mag[WORD_BITS-1:0]);
        status <= sat_neg ? ST_SAT : ST_OK;
      end else begin
        root   <= sat_pos ? {1'b0, {(WORD_BITS-1){1'b1}}} : dv_quo[WORD_BITS-1:0];
        status <= sat_pos ? ST_SAT : ST_OK;
      end
    end
  end

  assign m_tdata = {{(OUT_DATA_W - OUT_BITS){1'b0}}, status, root};

endmodule

@@ src/qnr_checker.sv @@
module qnr_checker
  import qnr_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  logic [1:0]           st;
  logic [WORD_BITS-1:0] rt;

  assign st = m_tdata[WORD_BITS+1:WORD_BITS];
  assign rt = m_tdata[WORD_BITS-1:0];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat dropped or changed while stalled");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (st == ST_NEG_DISC || st == ST_ZERO_A) |-> rt == '0)
    else $error("flagged beat carries nonzero root");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st == ST_SAT |->
      (rt == {1'b1, {(WORD_BITS-1){1'b0}}} || rt == {1'b0, {(WORD_BITS-1){1'b1}}}))
    else $error("saturated beat not at a range limit");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output space");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind quadratic_nearest_root_top qnr_checker u_qnr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
